// ----- rtl/pcrc_pkg.sv -----
// Shared constants and types for the parameterized CRC engine.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pcrc_pkg;

    // Largest CRC width the datapath is built for.
    localparam int MAX_WIDTH_DEF = 64;

    // Field widths of the stream and configuration ports.
    localparam int BYTE_W     = 8;
    localparam int CRC_OUT_W  = 64;
    localparam int WIDTH_W    = 7;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    // Smallest width the byte-wise update supports.
    localparam logic [WIDTH_W-1:0] MIN_WIDTH = 7'd8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_POLY        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_INIT        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_FINAL_XOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_REFLECT_IN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_REFLECT_OUT = 3'd5;

    // Reset values of the configuration registers (CRC-32).
    localparam logic [WIDTH_W-1:0]    RST_WIDTH       = 7'd32;
    localparam logic [CFG_DATA_W-1:0] RST_POLY        = 64'h0000_0000_04C1_1DB7;
    localparam logic [CFG_DATA_W-1:0] RST_INIT        = 64'h0000_0000_FFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] RST_FINAL_XOR   = 64'h0000_0000_FFFF_FFFF;
    localparam logic                  RST_REFLECT_IN  = 1'b1;
    localparam logic                  RST_REFLECT_OUT = 1'b1;

    // Bit-order controls handed from the register file to the datapath.
    typedef struct packed {
        logic refl_in;
        logic refl_out;
    } t_cfg_flags;

endpackage : pcrc_pkg

`default_nettype wire

// ----- rtl/pcrc_cfg.sv -----
// Configuration register file of the CRC engine, with the width-aligned
// operands derived from it. Depends on pcrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcrc_cfg #(
    parameter int MAX_WIDTH = pcrc_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [pcrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pcrc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output logic [$clog2(MAX_WIDTH)-1:0]          o_shift,
    output logic [MAX_WIDTH-1:0]                  o_poly_al,
    output logic [MAX_WIDTH-1:0]                  o_init_al,
    output logic [MAX_WIDTH-1:0]                  o_fxor_m,
    output pcrc_pkg::t_cfg_flags                  o_flags
);
    import pcrc_pkg::*;

    localparam int SH_W = $clog2(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0] MAX_W_CODE = WIDTH_W'(MAX_WIDTH);

    logic [WIDTH_W-1:0]   r_width;
    logic [MAX_WIDTH-1:0] r_poly;
    logic [MAX_WIDTH-1:0] r_init;
    logic [MAX_WIDTH-1:0] r_fxor;
    logic                 r_refl_in;
    logic                 r_refl_out;

    logic [WIDTH_W-1:0]   w_eff;
    logic [WIDTH_W-1:0]   w_shift_full;
    logic [SH_W-1:0]      w_shift;
    logic [MAX_WIDTH-1:0] w_mask;

    // Register writes; indexes outside the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= RST_WIDTH;
            r_poly     <= RST_POLY[MAX_WIDTH-1:0];
            r_init     <= RST_INIT[MAX_WIDTH-1:0];
            r_fxor     <= RST_FINAL_XOR[MAX_WIDTH-1:0];
            r_refl_in  <= RST_REFLECT_IN;
            r_refl_out <= RST_REFLECT_OUT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IDX_WIDTH:       r_width    <= i_cfg_wdata[WIDTH_W-1:0];
                CFG_IDX_POLY:        r_poly     <= i_cfg_wdata[MAX_WIDTH-1:0];
                CFG_IDX_INIT:        r_init     <= i_cfg_wdata[MAX_WIDTH-1:0];
                CFG_IDX_FINAL_XOR:   r_fxor     <= i_cfg_wdata[MAX_WIDTH-1:0];
                CFG_IDX_REFLECT_IN:  r_refl_in  <= i_cfg_wdata[0];
                CFG_IDX_REFLECT_OUT: r_refl_out <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Clamp the width into the supported range and turn it into a left
    // shift that places the register's top bit at the datapath MSB.
    always_comb begin
        if (r_width < MIN_WIDTH) begin
            w_eff = MIN_WIDTH;
        end else if (r_width > MAX_W_CODE) begin
            w_eff = MAX_W_CODE;
        end else begin
            w_eff = r_width;
        end
        w_shift_full = MAX_W_CODE - w_eff;
        w_shift      = w_shift_full[SH_W-1:0];
        w_mask       = {MAX_WIDTH{1'b1}} >> w_shift;
    end

    // Aligned operands are registered so the byte update sees no shifter.
    always_ff @(posedge i_clk) begin
        o_shift   <= w_shift;
        o_poly_al <= r_poly << w_shift;
        o_init_al <= r_init << w_shift;
        o_fxor_m  <= r_fxor & w_mask;
        o_flags   <= '{refl_in: r_refl_in, refl_out: r_refl_out};
    end

endmodule : pcrc_cfg

`default_nettype wire

// ----- rtl/pcrc_step.sv -----
// One-byte CRC register update on an MSB-aligned register: eight unrolled
// shift and conditional-XOR steps. Depends on pcrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcrc_step #(
    parameter int MAX_WIDTH = pcrc_pkg::MAX_WIDTH_DEF
) (
    input  wire logic [MAX_WIDTH-1:0]           i_crc_al,
    input  wire logic [pcrc_pkg::BYTE_W-1:0]    i_byte,
    input  wire logic                           i_refl_in,
    input  wire logic [MAX_WIDTH-1:0]           i_poly_al,
    output logic [MAX_WIDTH-1:0]                o_crc_al
);
    import pcrc_pkg::*;

    logic [BYTE_W-1:0]    w_byte;
    logic [MAX_WIDTH-1:0] w_c;

    always_comb begin
        // Optional bit reversal of the incoming byte.
        for (int i = 0; i < BYTE_W; i++) begin
            w_byte[i] = i_refl_in ? i_byte[BYTE_W-1-i] : i_byte[i];
        end

        // Fold the byte into the top of the register, then divide it out.
        w_c = i_crc_al ^ {w_byte, {(MAX_WIDTH-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++) begin
            if (w_c[MAX_WIDTH-1]) begin
                w_c = (w_c << 1) ^ i_poly_al;
            end else begin
                w_c = w_c << 1;
            end
        end
        o_crc_al = w_c;
    end

endmodule : pcrc_step

`default_nettype wire

// ----- rtl/pcrc_fin.sv -----
// Final CRC formatting: output reflection or realignment, final XOR.
// Depends on pcrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcrc_fin #(
    parameter int MAX_WIDTH = pcrc_pkg::MAX_WIDTH_DEF
) (
    input  wire logic [MAX_WIDTH-1:0]           i_crc_al,
    input  wire logic [$clog2(MAX_WIDTH)-1:0]   i_shift,
    input  wire logic                           i_refl_out,
    input  wire logic [MAX_WIDTH-1:0]           i_fxor_m,
    output logic [MAX_WIDTH-1:0]                o_crc
);
    logic [MAX_WIDTH-1:0] w_rev;
    logic [MAX_WIDTH-1:0] w_raw;

    // Reversing the aligned register over the full datapath width gives
    // the reflected CRC already right-justified; otherwise shift it down.
    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            w_rev[i] = i_crc_al[MAX_WIDTH-1-i];
        end
        w_raw = i_refl_out ? w_rev : (i_crc_al >> i_shift);
        o_crc = w_raw ^ i_fxor_m;
    end

endmodule : pcrc_fin

`default_nettype wire

// ----- rtl/parameterized_crc_engine_top.sv -----
// Parameterized CRC engine (widths 8 to MAX_WIDTH), top level.
// Depends on pcrc_pkg, pcrc_cfg, pcrc_step and pcrc_fin.
//
//   Channel     Direction  Word
//   s_axis      in         tdata = data_byte[7:0], tlast = last_byte
//   m_axis      out        tdata = crc_value[63:0], one word per message
//   cfg         in         write enable, register index, 64-bit data
//
// Each byte passes through the input register and is then folded into the
// CRC register; bytes enter back to back at one per cycle unless a last
// byte is held in the input register by an untaken result. The CRC of a
// message is written to the output register when its last byte leaves the
// input register. A register write is seen by bytes taken after it.
// A stalled result blocks only the next last byte; ordinary bytes still flow.
// Synchronous reset restores CRC-32 settings; input opens the cycle after release.
`timescale 1ns / 1ps
`default_nettype none

module parameterized_crc_engine_top #(
    parameter int MAX_WIDTH = pcrc_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input bytes.
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [pcrc_pkg::BYTE_W-1:0]      i_s_axis_tdata,  // data_byte[7:0]
    input  wire logic                             i_s_axis_tlast,
    // Finished CRC values.
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [pcrc_pkg::CRC_OUT_W-1:0]        o_m_axis_tdata,  // crc_value[63:0]
    // Configuration writes.
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [pcrc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pcrc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import pcrc_pkg::*;

    localparam int SH_W = $clog2(MAX_WIDTH);

    // Configuration outputs.
    logic [SH_W-1:0]      w_shift;
    logic [MAX_WIDTH-1:0] w_poly_al;
    logic [MAX_WIDTH-1:0] w_init_al;
    logic [MAX_WIDTH-1:0] w_fxor_m;
    t_cfg_flags           w_flags;

    // Pipeline state.
    logic                 r_run;
    logic                 r_in_valid;
    logic [BYTE_W-1:0]    r_in_byte;
    logic                 r_in_last;
    logic                 r_msg_start;
    logic [MAX_WIDTH-1:0] r_crc;
    logic                 r_out_valid;
    logic [MAX_WIDTH-1:0] r_out_crc;

    logic                 w_adv;
    logic                 w_take;
    logic [MAX_WIDTH-1:0] w_crc_cur;
    logic [MAX_WIDTH-1:0] w_crc_next;
    logic [MAX_WIDTH-1:0] w_crc_fin;

    pcrc_cfg #(.MAX_WIDTH(MAX_WIDTH)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_shift     (w_shift),
        .o_poly_al   (w_poly_al),
        .o_init_al   (w_init_al),
        .o_fxor_m    (w_fxor_m),
        .o_flags     (w_flags)
    );

    // A message's first byte starts from the initial value. The running CRC
    // is kept right-justified and aligned with the current width on use, so
    // a width change inside a message keeps the low bits of the register.
    assign w_crc_cur = r_msg_start ? w_init_al : (r_crc << w_shift);

    pcrc_step #(.MAX_WIDTH(MAX_WIDTH)) u_step (
        .i_crc_al  (w_crc_cur),
        .i_byte    (r_in_byte),
        .i_refl_in (w_flags.refl_in),
        .i_poly_al (w_poly_al),
        .o_crc_al  (w_crc_next)
    );

    pcrc_fin #(.MAX_WIDTH(MAX_WIDTH)) u_fin (
        .i_crc_al   (w_crc_next),
        .i_shift    (w_shift),
        .i_refl_out (w_flags.refl_out),
        .i_fxor_m   (w_fxor_m),
        .o_crc      (w_crc_fin)
    );

    // A byte leaves the input register unless it is a last byte and the
    // output register still holds an untaken word.
    assign w_adv  = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign w_take = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = r_run && (!r_in_valid || w_adv);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = CRC_OUT_W'(r_out_crc);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_in_valid  <= 1'b0;
            r_msg_start <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_msg_start <= r_in_last;
            end
            if (w_adv && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (w_adv) begin
            r_crc <= w_crc_next >> w_shift;
        end
        if (w_adv && r_in_last) begin
            r_out_crc <= w_crc_fin;
        end
    end

    // A new result word only comes from a last byte leaving the input stage.
    a_out_from_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(w_adv && r_in_last))
        else $error("result word appeared without a last byte");

    // After a last byte the next byte restarts from the initial value.
    a_restart_after_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_last) |=> r_msg_start)
        else $error("message start not set after last byte");

    // An ordinary byte keeps the message open.
    a_open_after_byte : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && !r_in_last) |=> !r_msg_start)
        else $error("message start set after a non-last byte");

    // A held byte is never overwritten by a new one.
    a_hold_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_byte)
                                    && $stable(r_in_last)))
        else $error("input register lost a byte");

    // No byte is taken before the block is running.
    a_closed_in_reset : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |-> !o_s_axis_tready)
        else $error("input open before start");

endmodule : parameterized_crc_engine_top

`default_nettype wire

// ----- bench/parameterized_crc_engine_top_tb.sv -----
// Self-checking bench for parameterized_crc_engine_top: directed CRC cases, then random messages.
// Depends on pcrc_pkg and the RTL of the block; a built-in CRC predictor supplies expected words.
`timescale 1ns / 1ps

module parameterized_crc_engine_top_tb;
    import pcrc_pkg::*;

    localparam int CLK_HALF_NS    = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_LIMIT    = 500;
    localparam int RANDOM_BYTES   = 1700;
    localparam int MAX_GAP        = 12;
    localparam int REPORT_LIMIT   = 10;
    localparam longint TIMEOUT_NS = 3_000_000;

    // Register indexes that the block decodes to nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [BYTE_W-1:0]     i_s_axis_tdata = '0;     // data_byte[7:0]
    logic                  i_s_axis_tlast = 1'b0;   // last_byte
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [CRC_OUT_W-1:0]  o_m_axis_tdata;          // crc_value[63:0]
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    // Predictor copy of the settings and of the running CRC.
    logic [WIDTH_W-1:0]    set_width = RST_WIDTH;
    logic [63:0]           set_poly = RST_POLY;
    logic [63:0]           set_init = RST_INIT;
    logic [63:0]           set_fxor = RST_FINAL_XOR;
    logic                  set_rin = RST_REFLECT_IN;
    logic                  set_rout = RST_REFLECT_OUT;
    logic [63:0]           crc_acc = '0;
    bit                    crc_fresh = 1'b1;

    // Finished CRC words still owed by the block, oldest first.
    logic [63:0]           pending_crcs[$];

    int                    error_count = 0;
    bit                    tx_calm = 1'b0;
    bit                    rx_calm = 1'b0;
    int                    rx_hold = 0;
    int                    rx_stall;
    logic [63:0]           rx_expected;

    parameterized_crc_engine_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Reverses the low n bits of a value.
    function automatic logic [63:0] reverse_bits(input logic [63:0] v, input int unsigned n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < n; i++) r[n - 1 - i] = v[i];
        return r;
    endfunction

    // Mirrors a register write into the predictor's settings.
    function automatic void model_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [63:0] value);
        case (idx)
            CFG_IDX_WIDTH:       set_width = value[WIDTH_W-1:0];
            CFG_IDX_POLY:        set_poly = value;
            CFG_IDX_INIT:        set_init = value;
            CFG_IDX_FINAL_XOR:   set_fxor = value;
            CFG_IDX_REFLECT_IN:  set_rin = value[0];
            CFG_IDX_REFLECT_OUT: set_rout = value[0];
            default: ;
        endcase
    endfunction

    // Folds one byte into the running CRC; returns 1 with the finished word on a last byte.
    function automatic bit absorb_byte(input logic [7:0] value, input logic is_last,
                                       output logic [63:0] crc_word);
        int unsigned w;
        logic [63:0] mask, top, poly_m, b, c;
        w = (set_width < MIN_WIDTH) ? 8 :
            (set_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : 32'(set_width);
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        top = 64'd1 << (w - 1);
        poly_m = set_poly & mask;
        crc_word = '0;
        if (crc_fresh) crc_acc = set_init & mask;
        b = set_rin ? reverse_bits({56'd0, value}, 8) : {56'd0, value};
        c = (crc_acc & mask) ^ (b << (w - 8));
        for (int k = 0; k < 8; k++) begin
            if ((c & top) != 0) c = (c << 1) ^ poly_m;
            else c = c << 1;
        end
        crc_acc = c & mask;
        crc_fresh = 1'b0;
        if (!is_last) return 1'b0;
        crc_word = ((set_rout ? reverse_bits(crc_acc, w) : crc_acc) ^ set_fxor) & mask;
        crc_acc = set_init & mask;
        crc_fresh = 1'b1;
        return 1'b1;
    endfunction

    function automatic void report_failure(input string what, input logic [63:0] exp_word,
                                           input logic [63:0] act_word);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s: expected %016h, actual %016h", $realtime, what, exp_word,
                     act_word);
    endfunction

    // Result side: checks each accepted word and draws a stall after it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_hold <= 0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_crcs.size() == 0) begin
                report_failure("CRC word with none expected", '0, o_m_axis_tdata);
            end else begin
                rx_expected = pending_crcs.pop_front();
                if (rx_expected !== o_m_axis_tdata)
                    report_failure("CRC mismatch", rx_expected, o_m_axis_tdata);
            end
            if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
            rx_stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (rx_stall == 0) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b0;
                rx_hold <= rx_stall;
            end
        end else if (rx_hold > 1) begin
            rx_hold <= rx_hold - 1;
        end else begin
            rx_hold <= 0;
            i_m_axis_tready <= 1'b1;
        end
    end

    // Offers one byte after a drawn gap and predicts its effect once it is taken.
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        logic [63:0] crc_word;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= value;
        i_s_axis_tlast <= is_last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (absorb_byte(value, is_last, crc_word))
            pending_crcs.insert(pending_crcs.size(), crc_word);
    endtask

    // Stops input and lets every owed word and any byte still in flight clear the block.
    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_crcs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        model_setting(idx, value);
    endtask

    // Writes all six registers plus a decoded-to-nothing index once the block is idle.
    task automatic load_settings(input logic [63:0] width_word, input logic [63:0] poly,
                                 input logic [63:0] init, input logic [63:0] fxor,
                                 input logic [63:0] rin_word, input logic [63:0] rout_word);
        wait_idle();
        write_register(CFG_IDX_WIDTH, width_word);
        write_register(CFG_IDX_POLY, poly);
        write_register(CFG_IDX_INIT, init);
        write_register(CFG_IDX_FINAL_XOR, fxor);
        write_register(CFG_IDX_REFLECT_IN, rin_word);
        write_register(CFG_IDX_REFLECT_OUT, rout_word);
        write_register($urandom_range(0, 1) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO,
                       {$urandom, $urandom});
        i_cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // Width word with random junk above the seven decoded bits.
    function automatic logic [63:0] pick_width_word();
        logic [63:0] word;
        word = rand_word();
        case ($urandom_range(0, 9))
            0: word[6:0] = 7'd8;
            1: word[6:0] = 7'd64;
            2: word[6:0] = 7'($urandom_range(0, 7));
            3: word[6:0] = 7'($urandom_range(65, 127));
            4: word[6:0] = 7'd16;
            5: word[6:0] = 7'd32;
            default: word[6:0] = 7'($urandom_range(8, 64));
        endcase
        return word;
    endfunction

    function automatic logic [63:0] pick_operand();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return rand_word();
        endcase
    endfunction

    // CRC-32 with reset settings: the standard check string and both byte extremes.
    task automatic test_reset_crc32();
        for (int i = 0; i < 9; i++) send_byte(8'(8'h31 + i), i == 8);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    // Smallest and largest widths, and width codes outside the legal range.
    task automatic test_width_limits();
        load_settings(64'd8, 64'h07, '0, '0, 64'd0, 64'd0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        load_settings(64'd64, 64'h42F0_E1EB_A9EA_3693, '1, '1, 64'd1, 64'd1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        load_settings(64'hFFFF_FFFF_FFFF_FF80, 64'h1D, '1, '0, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'hFFFF_FFFF_FFFF_FFFE);
        send_byte(8'h80, 1'b1);
        load_settings(64'h7F, '1, '0, '1, 64'd0, 64'd1);
        send_byte(8'h01, 1'b1);
    endtask

    // Operand bits above the width must have no effect.
    task automatic test_wide_operands();
        load_settings(64'd16, 64'hFFFF_FFFF_FFFF_1021, '1, 64'hAAAA_5555_0000_FFFF, 64'd0, 64'd0);
        send_byte(8'h3C, 1'b1);
    endtask

    // All four combinations of input and output reflection.
    task automatic test_reflect_modes();
        for (int mode = 0; mode < 4; mode++) begin
            load_settings(64'd24, 64'h86_4CFB, 64'hB7_04CE, '0, 64'(mode & 1),
                          64'((mode >> 1) & 1));
            send_byte(8'hC3, 1'b1);
        end
    endtask

    // Settings change between bytes of one message; later bytes use the new settings.
    task automatic test_reconfig_mid_message();
        load_settings(64'(RST_WIDTH), RST_POLY, RST_INIT, RST_FINAL_XOR, 64'(RST_REFLECT_IN),
                      64'(RST_REFLECT_OUT));
        send_byte(8'h31, 1'b0);
        send_byte(8'h32, 1'b0);
        load_settings(64'd16, 64'h8005, '0, '0, 64'd1, 64'd1);
        send_byte(8'h33, 1'b1);
    endtask

    // Random settings per phase, random messages, and some phases ending mid-message.
    task automatic test_random_traffic();
        int sent, phase_len, n, len;
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            load_settings(pick_width_word(), pick_operand(), pick_operand(), pick_operand(),
                          rand_word(), rand_word());
            phase_len = $urandom_range(40, 200);
            n = 0;
            while (n < phase_len) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
                for (int i = 0; i < len; i++)
                    send_byte(8'($urandom_range(0, 255)), i == len - 1);
                n += len;
            end
            // Leave a message open so the next settings apply part way through it.
            if (sent + n < RANDOM_BYTES && $urandom_range(0, 3) == 0) begin
                len = $urandom_range(1, 5);
                for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
                n += len;
            end
            sent += n;
        end
        // Close whatever message may still be open.
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        int waited;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_crc32();
        test_width_limits();
        test_wide_operands();
        test_reflect_modes();
        test_reconfig_mid_message();
        test_random_traffic();
        i_s_axis_tvalid <= 1'b0;
        waited = 0;
        while (pending_crcs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending_crcs.size() != 0)
            report_failure("CRC word never arrived", pending_crcs.pop_front(), 'x);
        if (error_count == 0) begin
            $display("parameterized_crc_engine_top_tb OK");
        end else begin
            $display("parameterized_crc_engine_top_tb NOT OK");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(TIMEOUT_NS);
        $display("parameterized_crc_engine_top_tb NOT OK");
        $finish;
    end

endmodule
